// ----- design/bcdc_pkg.sv -----
// Package for the BCD clock with alarm flasher.
// Holds the beat types, the command and register codes and the reset values.
// No dependencies.
package bcdc_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 8;

   localparam logic [1:0] CMD_SECOND = 2'd0;
   localparam logic [1:0] CMD_FLASH  = 2'd1;
   localparam logic [1:0] CMD_LOAD   = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ALARM_HOUR_TENS     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ALARM_HOUR_UNITS    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ALARM_MINUTE_TENS   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ALARM_MINUTE_UNITS  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FLASH_LIMIT         = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SECONDS_PER_MINUTE  = 3'd5;

   localparam logic [1:0] RST_ALARM_HOUR_TENS    = 2'd1;
   localparam logic [3:0] RST_ALARM_HOUR_UNITS   = 4'd2;
   localparam logic [2:0] RST_ALARM_MINUTE_TENS  = 3'd4;
   localparam logic [3:0] RST_ALARM_MINUTE_UNITS = 4'd5;
   localparam logic [7:0] RST_FLASH_LIMIT        = 8'd50;
   localparam logic [5:0] RST_SECONDS_PER_MINUTE = 6'd60;

   localparam logic [4:0] UNITS_MAX       = 5'd9;
   localparam logic [3:0] MINUTE_TENS_MAX = 4'd5;
   localparam logic [1:0] HOUR_TENS_TOP   = 2'd2;
   localparam logic [1:0] HOUR_TENS_BAD   = 2'd3;
   localparam logic [3:0] HOUR_UNITS_TOP  = 4'd3;
   localparam logic [7:0] FLASH_COUNT_MAX = 8'd255;

   typedef struct packed {
      logic [1:0] command;
      logic [1:0] load_hour_tens;
      logic [3:0] load_hour_units;
      logic [2:0] load_minute_tens;
      logic [3:0] load_minute_units;
   } req_type;

   typedef struct packed {
      logic [1:0] hour_tens;
      logic [3:0] hour_units;
      logic [2:0] minute_tens;
      logic [3:0] minute_units;
      logic       alarm_match;
      logic       led_pulse;
      logic       alarm_locked;
   } rsp_type;

   typedef struct packed {
      logic [1:0] alarm_hour_tens;
      logic [3:0] alarm_hour_units;
      logic [2:0] alarm_minute_tens;
      logic [3:0] alarm_minute_units;
      logic [7:0] flash_limit;
      logic [5:0] seconds_per_minute;
   } cfg_type;

   typedef struct packed {
      logic [5:0] second_count;
      logic [1:0] hour_tens;
      logic [3:0] hour_units;
      logic [2:0] minute_tens;
      logic [3:0] minute_units;
      logic [7:0] flash_count;
      logic       lock_flag;
   } clock_state_type;

endpackage

// ----- design/bcd_clock_with_alarm_flash_top.sv -----
// Top level of the BCD 24-hour clock with alarm flasher.
// Depends on bcdc_pkg and bcdc_step.
//
//   channel  ports                              payload
//   req      req_valid / req_stall / req_data    bcdc_pkg::req_type
//   rsp      rsp_valid / rsp_stall / rsp_data    bcdc_pkg::rsp_type
//   csr      csr_valid / csr_ready / csr_index   csr_data, 8 bits
//
// One beat per cycle sustained while rsp is not stalled; an accepted beat goes from the input
// register through the update pass to the result register driving rsp. The rate is set by
// the single update pass between them. Synchronous reset clears the time, the flasher and the
// valids; the config registers take their defaults. A stalled rsp holds one more req beat in
// the input register, then stalls req. csr_ready is always high.
module bcd_clock_with_alarm_flash_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  bcdc_pkg::req_type                        req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output bcdc_pkg::rsp_type                        rsp_data,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [bcdc_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [bcdc_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);

   logic                      in_valid_ff;
   logic                      in_valid_in;
   bcdc_pkg::req_type         in_data_ff;
   logic                      out_valid_ff;
   logic                      out_valid_in;
   bcdc_pkg::rsp_type         out_data_ff;
   bcdc_pkg::clock_state_type state_ff;
   bcdc_pkg::clock_state_type state_in;
   bcdc_pkg::cfg_type         cfg_ff;
   bcdc_pkg::rsp_type         result;
   logic                      advance;
   logic                      req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   bcdc_step u_step (
      .cfg    (cfg_ff),
      .cur    (state_ff),
      .item   (in_data_ff),
      .nxt    (state_in),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alarm_hour_tens    <= bcdc_pkg::RST_ALARM_HOUR_TENS;
         cfg_ff.alarm_hour_units   <= bcdc_pkg::RST_ALARM_HOUR_UNITS;
         cfg_ff.alarm_minute_tens  <= bcdc_pkg::RST_ALARM_MINUTE_TENS;
         cfg_ff.alarm_minute_units <= bcdc_pkg::RST_ALARM_MINUTE_UNITS;
         cfg_ff.flash_limit        <= bcdc_pkg::RST_FLASH_LIMIT;
         cfg_ff.seconds_per_minute <= bcdc_pkg::RST_SECONDS_PER_MINUTE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bcdc_pkg::REG_ALARM_HOUR_TENS:    cfg_ff.alarm_hour_tens    <= csr_data[1:0];
            bcdc_pkg::REG_ALARM_HOUR_UNITS:   cfg_ff.alarm_hour_units   <= csr_data[3:0];
            bcdc_pkg::REG_ALARM_MINUTE_TENS:  cfg_ff.alarm_minute_tens  <= csr_data[2:0];
            bcdc_pkg::REG_ALARM_MINUTE_UNITS: cfg_ff.alarm_minute_units <= csr_data[3:0];
            bcdc_pkg::REG_FLASH_LIMIT:        cfg_ff.flash_limit        <= csr_data;
            bcdc_pkg::REG_SECONDS_PER_MINUTE: cfg_ff.seconds_per_minute <= csr_data[5:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ----- design/bcdc_step.sv -----
// Next-state and result logic of the BCD clock for one beat.
// Purely combinational; depends on bcdc_pkg.
module bcdc_step (
   input  bcdc_pkg::cfg_type         cfg,
   input  bcdc_pkg::clock_state_type cur,
   input  bcdc_pkg::req_type         item,
   output bcdc_pkg::clock_state_type nxt,
   output bcdc_pkg::rsp_type         result
);

   logic [5:0] sec_inc;
   logic [4:0] mu_inc;
   logic       mu_wrap;
   logic [3:0] mt_step;
   logic       hour_wrap;
   logic [4:0] hu_inc;
   logic [8:0] fc_inc;
   logic       match;
   logic       pulse;

   assign sec_inc   = cur.second_count + 6'd1;
   assign mu_inc    = {1'b0, cur.minute_units} + 5'd1;
   assign mu_wrap   = mu_inc > bcdc_pkg::UNITS_MAX;
   assign mt_step   = {1'b0, cur.minute_tens} + {3'b000, mu_wrap};
   assign hour_wrap = (cur.hour_tens == bcdc_pkg::HOUR_TENS_BAD)
                   || (cur.hour_tens == bcdc_pkg::HOUR_TENS_TOP
                       && cur.hour_units >= bcdc_pkg::HOUR_UNITS_TOP);
   assign hu_inc    = {1'b0, cur.hour_units} + 5'd1;
   assign fc_inc    = {1'b0, cur.flash_count} + 9'd1;

   always_comb begin
      nxt   = cur;
      pulse = 1'b0;
      unique case (item.command)
         bcdc_pkg::CMD_SECOND: begin
            if (sec_inc >= cfg.seconds_per_minute) begin
               nxt.second_count = 6'd0;
               if (mt_step > bcdc_pkg::MINUTE_TENS_MAX) begin
                  nxt.minute_tens  = 3'd0;
                  nxt.minute_units = 4'd0;
                  if (hour_wrap) begin
                     nxt.hour_tens  = 2'd0;
                     nxt.hour_units = 4'd0;
                  end else if (hu_inc > bcdc_pkg::UNITS_MAX) begin
                     nxt.hour_units = 4'd0;
                     nxt.hour_tens  = cur.hour_tens + 2'd1;
                  end else begin
                     nxt.hour_units = hu_inc[3:0];
                  end
               end else begin
                  nxt.minute_tens  = mt_step[2:0];
                  nxt.minute_units = mu_wrap ? 4'd0 : mu_inc[3:0];
               end
            end else begin
               nxt.second_count = sec_inc;
            end
         end
         bcdc_pkg::CMD_LOAD: begin
            nxt.hour_tens    = item.load_hour_tens;
            nxt.hour_units   = item.load_hour_units;
            nxt.minute_tens  = item.load_minute_tens;
            nxt.minute_units = item.load_minute_units;
            nxt.second_count = 6'd0;
         end
         default: begin
         end
      endcase

      match = nxt.hour_tens == cfg.alarm_hour_tens
           && nxt.hour_units == cfg.alarm_hour_units
           && nxt.minute_tens == cfg.alarm_minute_tens
           && nxt.minute_units == cfg.alarm_minute_units;

      if (match) begin
         if (item.command == bcdc_pkg::CMD_FLASH && cur.flash_count <= cfg.flash_limit
             && !cur.lock_flag) begin
            pulse = 1'b1;
            if (fc_inc > {1'b0, cfg.flash_limit}) begin
               nxt.lock_flag = 1'b1;
            end
            nxt.flash_count = fc_inc[8] ? bcdc_pkg::FLASH_COUNT_MAX : fc_inc[7:0];
         end
         if (nxt.flash_count > cfg.flash_limit) begin
            nxt.lock_flag = 1'b1;
         end
      end else begin
         nxt.flash_count = 8'd0;
         nxt.lock_flag   = 1'b0;
      end

      result.hour_tens    = nxt.hour_tens;
      result.hour_units   = nxt.hour_units;
      result.minute_tens  = nxt.minute_tens;
      result.minute_units = nxt.minute_units;
      result.alarm_match  = match;
      result.led_pulse    = pulse;
      result.alarm_locked = nxt.lock_flag;
   end

endmodule

// ----- design/bcdc_checker.sv -----
// Port-level checker for the BCD clock top level, with its bind.
// Depends on bcdc_pkg and bcd_clock_with_alarm_flash_top.
module bcdc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input bcdc_pkg::req_type                    req_data,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input bcdc_pkg::rsp_type                    rsp_data,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic [bcdc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [bcdc_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   a_pulse_needs_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.led_pulse |-> rsp_data.alarm_match)
      else $error("led pulse without alarm match");

   a_lock_needs_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.alarm_locked |-> rsp_data.alarm_match)
      else $error("alarm locked without alarm match");

   a_no_req_stall_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("req stalled while rsp is free");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed");

endmodule

bind bcd_clock_with_alarm_flash_top bcdc_checker u_checker (.*);

// ----- tb/tb_bcd_clock_with_alarm_flash_top.sv -----
// Self-checking testbench for bcd_clock_with_alarm_flash_top: ticks, flash ticks and time
// loads go in, every reading is predicted in the bench and compared beat by beat.
// Depends on bcdc_pkg and the top-level RTL.
module tb_bcd_clock_with_alarm_flash_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam logic [bcdc_pkg::CSR_INDEX_WIDTH-1:0] REG_SPARE_LOW  = 3'd6;
   localparam logic [bcdc_pkg::CSR_INDEX_WIDTH-1:0] REG_SPARE_HIGH = 3'd7;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int QUIET_LIMIT     = 1000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int MAX_PRINTS      = 100;

   logic                                 clock     = 1'b0;
   logic                                 reset     = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   bcdc_pkg::req_type                    req_data  = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   bcdc_pkg::rsp_type                    rsp_data;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [bcdc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [bcdc_pkg::CSR_DATA_WIDTH-1:0]  csr_data  = '0;

   bcdc_pkg::cfg_type         alarm_cfg;
   bcdc_pkg::clock_state_type now_state;
   bcdc_pkg::rsp_type         expected_readings[$];
   int                        fail_count       = 0;
   int                        quiet_cycles     = 0;
   bit                        gaps_on          = 1'b1;
   bit                        hold_off_pending = 1'b0;

   bcd_clock_with_alarm_flash_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic bcdc_pkg::cfg_type make_cfg(input int ht, input int hu, input int mt,
                                                  input int mu, input int limit,
                                                  input int spm);
      bcdc_pkg::cfg_type c;
      c.alarm_hour_tens    = ht[1:0];
      c.alarm_hour_units   = hu[3:0];
      c.alarm_minute_tens  = mt[2:0];
      c.alarm_minute_units = mu[3:0];
      c.flash_limit        = limit[7:0];
      c.seconds_per_minute = spm[5:0];
      return c;
   endfunction

   function automatic bcdc_pkg::rsp_type predict_reading(input bcdc_pkg::req_type beat);
      bcdc_pkg::rsp_type reading;
      logic [4:0]        units_up;
      logic [3:0]        tens_up;
      logic [8:0]        count_up;
      logic              match;
      reading = '0;
      if (beat.command == bcdc_pkg::CMD_SECOND) begin
         now_state.second_count = now_state.second_count + 6'd1;
         if (now_state.second_count >= alarm_cfg.seconds_per_minute) begin
            now_state.second_count = '0;
            units_up = {1'b0, now_state.minute_units} + 5'd1;
            tens_up  = {1'b0, now_state.minute_tens};
            if (units_up > bcdc_pkg::UNITS_MAX) begin
               units_up = '0;
               tens_up  = tens_up + 4'd1;
            end
            now_state.minute_units = units_up[3:0];
            if (tens_up > bcdc_pkg::MINUTE_TENS_MAX) begin
               now_state.minute_tens  = '0;
               now_state.minute_units = '0;
               if (now_state.hour_tens == bcdc_pkg::HOUR_TENS_BAD ||
                   (now_state.hour_tens == bcdc_pkg::HOUR_TENS_TOP &&
                    now_state.hour_units >= bcdc_pkg::HOUR_UNITS_TOP)) begin
                  now_state.hour_tens  = '0;
                  now_state.hour_units = '0;
               end else begin
                  units_up = {1'b0, now_state.hour_units} + 5'd1;
                  if (units_up > bcdc_pkg::UNITS_MAX) begin
                     now_state.hour_units = '0;
                     now_state.hour_tens  = now_state.hour_tens + 2'd1;
                  end else begin
                     now_state.hour_units = units_up[3:0];
                  end
               end
            end else begin
               now_state.minute_tens = tens_up[2:0];
            end
         end
      end else if (beat.command == bcdc_pkg::CMD_LOAD) begin
         now_state.hour_tens    = beat.load_hour_tens;
         now_state.hour_units   = beat.load_hour_units;
         now_state.minute_tens  = beat.load_minute_tens;
         now_state.minute_units = beat.load_minute_units;
         now_state.second_count = '0;
      end

      match = now_state.hour_tens == alarm_cfg.alarm_hour_tens &&
              now_state.hour_units == alarm_cfg.alarm_hour_units &&
              now_state.minute_tens == alarm_cfg.alarm_minute_tens &&
              now_state.minute_units == alarm_cfg.alarm_minute_units;

      if (match) begin
         if (beat.command == bcdc_pkg::CMD_FLASH &&
             now_state.flash_count <= alarm_cfg.flash_limit && !now_state.lock_flag) begin
            count_up = {1'b0, now_state.flash_count} + 9'd1;
            reading.led_pulse = 1'b1;
            if (count_up > alarm_cfg.flash_limit) now_state.lock_flag = 1'b1;
            now_state.flash_count = (count_up > bcdc_pkg::FLASH_COUNT_MAX)
                                    ? bcdc_pkg::FLASH_COUNT_MAX : count_up[7:0];
         end
         if (now_state.flash_count > alarm_cfg.flash_limit) now_state.lock_flag = 1'b1;
      end else begin
         now_state.flash_count = '0;
         now_state.lock_flag   = 1'b0;
      end

      reading.hour_tens    = now_state.hour_tens;
      reading.hour_units   = now_state.hour_units;
      reading.minute_tens  = now_state.minute_tens;
      reading.minute_units = now_state.minute_units;
      reading.alarm_match  = match;
      reading.alarm_locked = now_state.lock_flag;
      return reading;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      fail_count++;
      if (fail_count <= MAX_PRINTS)
         $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin : check_readings
      bcdc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readings.size() == 0) begin
            report_mismatch("reading with none outstanding", 0, rsp_data);
         end else begin
            want = expected_readings.pop_front();
            if (rsp_data.hour_tens !== want.hour_tens)
               report_mismatch("hour_tens", want.hour_tens, rsp_data.hour_tens);
            if (rsp_data.hour_units !== want.hour_units)
               report_mismatch("hour_units", want.hour_units, rsp_data.hour_units);
            if (rsp_data.minute_tens !== want.minute_tens)
               report_mismatch("minute_tens", want.minute_tens, rsp_data.minute_tens);
            if (rsp_data.minute_units !== want.minute_units)
               report_mismatch("minute_units", want.minute_units, rsp_data.minute_units);
            if (rsp_data.alarm_match !== want.alarm_match)
               report_mismatch("alarm_match", want.alarm_match, rsp_data.alarm_match);
            if (rsp_data.led_pulse !== want.led_pulse)
               report_mismatch("led_pulse", want.led_pulse, rsp_data.led_pulse);
            if (rsp_data.alarm_locked !== want.alarm_locked)
               report_mismatch("alarm_locked", want.alarm_locked, rsp_data.alarm_locked);
         end
      end
   end

   initial begin : rsp_pacing
      int n;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (gaps_on) begin
            n = pick_gap();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[bcd_clock_with_alarm_flash_top] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_beat(input bcdc_pkg::req_type beat);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_readings.push_back(predict_reading(beat));
   endtask

   task automatic send_cmd(input logic [1:0] cmd);
      bcdc_pkg::req_type beat;
      logic [31:0]       r;
      r = $urandom;
      beat = r[$bits(bcdc_pkg::req_type)-1:0];
      beat.command = cmd;
      send_beat(beat);
   endtask

   task automatic send_load(input int ht, input int hu, input int mt, input int mu);
      bcdc_pkg::req_type beat;
      beat.command           = bcdc_pkg::CMD_LOAD;
      beat.load_hour_tens    = ht[1:0];
      beat.load_hour_units   = hu[3:0];
      beat.load_minute_tens  = mt[2:0];
      beat.load_minute_units = mu[3:0];
      send_beat(beat);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [bcdc_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [bcdc_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         bcdc_pkg::REG_ALARM_HOUR_TENS:    alarm_cfg.alarm_hour_tens    = value[1:0];
         bcdc_pkg::REG_ALARM_HOUR_UNITS:   alarm_cfg.alarm_hour_units   = value[3:0];
         bcdc_pkg::REG_ALARM_MINUTE_TENS:  alarm_cfg.alarm_minute_tens  = value[2:0];
         bcdc_pkg::REG_ALARM_MINUTE_UNITS: alarm_cfg.alarm_minute_units = value[3:0];
         bcdc_pkg::REG_FLASH_LIMIT:        alarm_cfg.flash_limit        = value;
         bcdc_pkg::REG_SECONDS_PER_MINUTE: alarm_cfg.seconds_per_minute = value[5:0];
         default: ;
      endcase
   endtask

   task automatic configure(input bcdc_pkg::cfg_type c);
      logic [31:0] noise;
      noise = $urandom;
      write_reg(bcdc_pkg::REG_ALARM_HOUR_TENS,    {noise[7:2], c.alarm_hour_tens});
      write_reg(bcdc_pkg::REG_ALARM_HOUR_UNITS,   {noise[11:8], c.alarm_hour_units});
      write_reg(bcdc_pkg::REG_ALARM_MINUTE_TENS,  {noise[16:12], c.alarm_minute_tens});
      write_reg(bcdc_pkg::REG_ALARM_MINUTE_UNITS, {noise[20:17], c.alarm_minute_units});
      write_reg(bcdc_pkg::REG_FLASH_LIMIT,        c.flash_limit);
      write_reg(bcdc_pkg::REG_SECONDS_PER_MINUTE, {noise[22:21], c.seconds_per_minute});
      write_reg(REG_SPARE_LOW,                    noise[31:24]);
      write_reg(REG_SPARE_HIGH,                   ~noise[31:24]);
      csr_valid <= 1'b0;
   endtask

   function automatic bcdc_pkg::cfg_type random_cfg();
      bcdc_pkg::cfg_type c;
      logic [31:0]       r;
      int                h, m, pick;
      r = $urandom;
      c = r[$bits(bcdc_pkg::cfg_type)-1:0];
      if ($urandom_range(0, 9) != 0) begin
         h = $urandom_range(0, 23);
         m = $urandom_range(0, 59);
         c = make_cfg(h / 10, h % 10, m / 10, m % 10, c.flash_limit, c.seconds_per_minute);
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         r = $urandom_range(0, 6);
         c.flash_limit = r[7:0];
      end else if (pick == 6) begin
         c.flash_limit = '0;
      end else if (pick == 7) begin
         c.flash_limit = bcdc_pkg::FLASH_COUNT_MAX;
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         r = $urandom_range(1, 4);
         c.seconds_per_minute = r[5:0];
      end else if (pick == 5) begin
         c.seconds_per_minute = '0;
      end else if (pick == 6) begin
         c.seconds_per_minute = '1;
      end else if (pick == 7) begin
         c.seconds_per_minute = bcdc_pkg::RST_SECONDS_PER_MINUTE;
      end
      return c;
   endfunction

   // loads mostly land at or just before the alarm time, so the flasher and lock get exercised
   function automatic bcdc_pkg::req_type random_beat();
      bcdc_pkg::req_type beat;
      logic [31:0]       r;
      int                pick, h, m, ht, hu, mt, mu;
      r = $urandom;
      beat = r[$bits(bcdc_pkg::req_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         beat.command = bcdc_pkg::CMD_SECOND;
      end else if (pick < 75) begin
         beat.command = bcdc_pkg::CMD_FLASH;
      end else if (pick < 95) begin
         beat.command = bcdc_pkg::CMD_LOAD;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            beat.load_hour_tens    = alarm_cfg.alarm_hour_tens;
            beat.load_hour_units   = alarm_cfg.alarm_hour_units;
            beat.load_minute_tens  = alarm_cfg.alarm_minute_tens;
            beat.load_minute_units = alarm_cfg.alarm_minute_units;
            if (pick >= 45 && alarm_cfg.alarm_minute_units != 4'd0)
               beat.load_minute_units = alarm_cfg.alarm_minute_units - 4'd1;
         end else if (pick < 90) begin
            h  = $urandom_range(0, 23);
            m  = $urandom_range(0, 59);
            ht = h / 10;
            hu = h % 10;
            mt = m / 10;
            mu = m % 10;
            beat.load_hour_tens    = ht[1:0];
            beat.load_hour_units   = hu[3:0];
            beat.load_minute_tens  = mt[2:0];
            beat.load_minute_units = mu[3:0];
         end
      end else begin
         beat.command = CMD_SPARE;
      end
      return beat;
   endfunction

   task automatic test_directed_digits();
      send_cmd(bcdc_pkg::CMD_SECOND);
      send_load(1, 2, 4, 5);
      send_cmd(bcdc_pkg::CMD_FLASH);
      wait_for_drain();
      configure(make_cfg(2, 3, 5, 9, 2, 1));
      send_load(2, 3, 5, 8);
      send_cmd(bcdc_pkg::CMD_SECOND);
      repeat (4) send_cmd(bcdc_pkg::CMD_FLASH);
      send_cmd(bcdc_pkg::CMD_SECOND);
      send_cmd(CMD_SPARE);
      send_load(3, 15, 7, 15);
      send_cmd(CMD_SPARE);
      send_cmd(bcdc_pkg::CMD_SECOND);
      send_load(0, 9, 5, 9);
      send_cmd(bcdc_pkg::CMD_SECOND);
      send_load(1, 9, 5, 9);
      send_cmd(bcdc_pkg::CMD_SECOND);
      send_load(2, 2, 5, 9);
      send_cmd(bcdc_pkg::CMD_SECOND);
      send_load(0, 15, 5, 9);
      send_cmd(bcdc_pkg::CMD_SECOND);
      send_load(0, 0, 0, 0);
      send_cmd(bcdc_pkg::CMD_FLASH);
      send_load(2, 3, 5, 9);
      send_cmd(bcdc_pkg::CMD_FLASH);
      wait_for_drain();
   endtask

   task automatic test_minute_length();
      configure(make_cfg(0, 0, 0, 1, 50, 0));
      send_load(0, 0, 0, 0);
      repeat (3) send_cmd(bcdc_pkg::CMD_SECOND);
      wait_for_drain();
      configure(make_cfg(0, 0, 0, 1, 50, 63));
      send_load(0, 0, 0, 0);
      repeat (64) send_cmd(bcdc_pkg::CMD_SECOND);
      wait_for_drain();
      configure(make_cfg(1, 2, 4, 5, 50, 60));
      send_load(1, 2, 4, 4);
      repeat (5) send_cmd(bcdc_pkg::CMD_SECOND);
      wait_for_drain();
      configure(make_cfg(1, 2, 4, 5, 50, 3));
      send_cmd(bcdc_pkg::CMD_SECOND);
      send_cmd(bcdc_pkg::CMD_FLASH);
      wait_for_drain();
   endtask

   task automatic test_flash_limits();
      configure(make_cfg(0, 7, 3, 0, 0, 60));
      send_load(0, 0, 0, 0);
      send_load(0, 7, 3, 0);
      repeat (3) send_cmd(bcdc_pkg::CMD_FLASH);
      wait_for_drain();
      configure(make_cfg(0, 7, 3, 0, 255, 60));
      send_load(0, 0, 0, 0);
      send_load(0, 7, 3, 0);
      repeat (258) send_cmd(bcdc_pkg::CMD_FLASH);
      wait_for_drain();
      configure(make_cfg(0, 7, 3, 0, 50, 60));
      send_load(0, 0, 0, 0);
      send_load(0, 7, 3, 0);
      repeat (10) send_cmd(bcdc_pkg::CMD_FLASH);
      wait_for_drain();
      configure(make_cfg(0, 7, 3, 0, 3, 60));
      send_cmd(bcdc_pkg::CMD_FLASH);
      send_cmd(bcdc_pkg::CMD_SECOND);
      send_load(1, 1, 1, 1);
      send_cmd(bcdc_pkg::CMD_FLASH);
      wait_for_drain();
   endtask

   task automatic test_stall_fill();
      configure(random_cfg());
      gaps_on = 1'b0;
      hold_off_pending = 1'b1;
      repeat (40) send_beat(random_beat());
      wait_for_drain();
      gaps_on = 1'b1;
   endtask

   task automatic test_drain_pause();
      repeat (20) send_beat(random_beat());
      wait_for_drain();
      repeat (20) send_beat(random_beat());
      wait_for_drain();
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < 8; phase++) begin
         configure(random_cfg());
         gaps_on = (phase == 1 || $urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
         repeat (50) send_beat(random_beat());
         wait_for_drain();
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      alarm_cfg = {bcdc_pkg::RST_ALARM_HOUR_TENS, bcdc_pkg::RST_ALARM_HOUR_UNITS,
                   bcdc_pkg::RST_ALARM_MINUTE_TENS, bcdc_pkg::RST_ALARM_MINUTE_UNITS,
                   bcdc_pkg::RST_FLASH_LIMIT, bcdc_pkg::RST_SECONDS_PER_MINUTE};
      now_state = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_digits();
      test_minute_length();
      test_flash_limits();
      test_stall_fill();
      test_drain_pause();
      test_random_phases();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_readings.size() != 0)
         report_mismatch("readings still outstanding", 0, expected_readings.size());
      if (fail_count == 0)
         $display("[bcd_clock_with_alarm_flash_top] OK");
      else
         $display("[bcd_clock_with_alarm_flash_top] ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
design/bcdc_pkg.sv
design/bcdc_step.sv
design/bcd_clock_with_alarm_flash_top.sv
design/bcdc_checker.sv
tb/tb_bcd_clock_with_alarm_flash_top.sv
